>>> hdl/lapedge_pkg.sv
// shared constants, types and helpers of the 3x3 laplacian edge filter
`default_nettype none

package lapedge_pkg;

    // frame size limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    // field and counter widths
    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int HEIGHT_W   = $clog2(MAX_HEIGHT + 1);
    localparam int NSUM_W     = PIX_W + 3;
    localparam int SUM_W      = PIX_W + 4;
    localparam int THR_W      = 12;
    localparam int CFG_WIDTH_FIELD_W  = 12;
    localparam int CFG_HEIGHT_FIELD_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

    // action codes
    localparam logic ACTION_PIXEL = 1'b0;
    localparam logic ACTION_DRAIN = 1'b1;

    // register reset values and clamp limits
    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = HEIGHT_W'(480);
    localparam logic [WIDTH_W-1:0]  MIN_WIDTH  = WIDTH_W'(2);
    localparam logic [HEIGHT_W-1:0] MIN_HEIGHT = HEIGHT_W'(2);
    localparam logic [WIDTH_W-1:0]  LIM_WIDTH  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] LIM_HEIGHT = HEIGHT_W'(MAX_HEIGHT);

    typedef logic [PIX_W-1:0] t_pixel;

    // one column of the window, top row first
    typedef struct packed {
        t_pixel top;
        t_pixel mid;
        t_pixel bot;
    } t_column;

    // one line store entry: the two rows above the incoming one
    typedef struct packed {
        t_pixel older;
        t_pixel newer;
    } t_line_pair;

    // control that travels with one step down the pipeline
    typedef struct packed {
        logic             emit;
        logic             is_pixel;
        logic             left_ref;
        logic             right_ref;
        logic             top_ref;
        logic             bot_ref;
        logic             frame_end;
        logic [COL_W-1:0] addr;
    } t_step;

    // one result item
    typedef struct packed {
        logic signed [SUM_W-1:0] edge_sum;
        logic                    is_edge;
        logic                    row_end;
        logic                    frame_end;
    } t_result;

    // reflect-101 at the top and bottom frame border
    function automatic t_column reflect_rows(input t_column col, input logic top_ref,
                                             input logic bot_ref);
        t_column res;
        res     = col;
        if (top_ref) begin
            res.top = col.bot;
        end
        if (bot_ref) begin
            res.bot = col.top;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hdl/laplacian_edge_threshold_3x3.sv
// top level of the streaming 3x3 laplacian edge filter with threshold flag
`default_nettype none

// Streaming 8-neighbour laplacian (8 x centre minus the eight neighbours) with
// reflect-101 borders and an edge flag set when the sum exceeds edge_threshold.
// The block takes one transfer per clock, pixel or drain, while the skid stage
// is empty, and each one goes through a three-stage pipeline: line store read,
// column shift and window sum, then the output register. Results lag the
// pixel stream by image_width+1 pixels, so after the last pixel of a frame
// image_width+1 drain transfers release the remaining results; a drain at any
// other time yields nothing, and a pixel at the frame start abandons results
// still pending. The line store is one MAX_WIDTH x 16-bit memory with one
// read and one write port, holding the two previous rows per column; it needs
// no clearing pass after reset. Registers must be written only while the
// block is idle; the block itself does not enforce this.
module laplacian_edge_threshold_3x3 (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration write channel
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [lapedge_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lapedge_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input channel
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic                                   i_action,
    input  wire logic [lapedge_pkg::PIX_W-1:0]          i_pixel_value,
    // result channel
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed [lapedge_pkg::SUM_W-1:0]        o_edge_sum,
    output logic                                        o_is_edge,
    output logic                                        o_row_end,
    output logic                                        o_frame_end
);

    // configuration registers, stored already clamped
    logic [lapedge_pkg::WIDTH_W-1:0]            r_width;
    logic [lapedge_pkg::HEIGHT_W-1:0]           r_height;
    logic signed [lapedge_pkg::THR_W-1:0]       r_threshold;
    logic [lapedge_pkg::CFG_WIDTH_FIELD_W-1:0]  cfg_width_raw;
    logic [lapedge_pkg::CFG_HEIGHT_FIELD_W-1:0] cfg_height_raw;
    logic [lapedge_pkg::WIDTH_W-1:0]            cfg_width_clamped;
    logic [lapedge_pkg::HEIGHT_W-1:0]           cfg_height_clamped;

    // raster position and drain tracking
    logic [lapedge_pkg::COL_W-1:0]    r_in_col;
    logic [lapedge_pkg::ROW_W-1:0]    r_in_row;
    logic                             r_drain_act;
    logic [lapedge_pkg::WIDTH_W-1:0]  r_drain_col;
    logic [lapedge_pkg::WIDTH_W-1:0]  in_col_next;
    logic [lapedge_pkg::HEIGHT_W-1:0] in_row_next;

    // step decode
    logic                             in_xfer;
    logic                             is_drain;
    logic                             step_go;
    logic [lapedge_pkg::HEIGHT_W-1:0] step_row;
    logic [lapedge_pkg::WIDTH_W-1:0]  step_col;
    logic                             step_col_zero;
    lapedge_pkg::t_step               step0;

    // line store and stage 1
    lapedge_pkg::t_line_pair          r_line_mem [lapedge_pkg::MAX_WIDTH];
    lapedge_pkg::t_line_pair          r_rd_pair;
    logic                             r_s1_valid;
    lapedge_pkg::t_step               r_s1_step;
    lapedge_pkg::t_pixel              r_s1_pixel;
    lapedge_pkg::t_column             col_new;

    // column shift and stage 2
    lapedge_pkg::t_column [2:0]       r_col;
    logic                             r_s2_valid;
    lapedge_pkg::t_step               r_s2_step;
    lapedge_pkg::t_column             win_left;
    lapedge_pkg::t_column             win_mid;
    lapedge_pkg::t_column             win_right;
    logic [lapedge_pkg::NSUM_W-1:0]   neigh_sum;
    logic [lapedge_pkg::NSUM_W-1:0]   centre8;
    logic [lapedge_pkg::SUM_W-1:0]    diff;
    lapedge_pkg::t_result             result;

    // output register and skid stage
    logic                             r_out_valid;
    logic                             r_skid_valid;
    lapedge_pkg::t_result             r_out;
    lapedge_pkg::t_result             r_skid;

    // configuration port, always ready
    assign o_cfg_ready    = 1'b1;
    assign cfg_width_raw  = i_cfg_data[lapedge_pkg::CFG_WIDTH_FIELD_W-1:0];
    assign cfg_height_raw = i_cfg_data[lapedge_pkg::CFG_HEIGHT_FIELD_W-1:0];

    // clamp the frame size into the supported range
    always_comb begin
        if (lapedge_pkg::WIDTH_W'(cfg_width_raw) < lapedge_pkg::MIN_WIDTH) begin
            cfg_width_clamped = lapedge_pkg::MIN_WIDTH;
        end else if (lapedge_pkg::WIDTH_W'(cfg_width_raw) > lapedge_pkg::LIM_WIDTH) begin
            cfg_width_clamped = lapedge_pkg::LIM_WIDTH;
        end else begin
            cfg_width_clamped = lapedge_pkg::WIDTH_W'(cfg_width_raw);
        end
        if (lapedge_pkg::HEIGHT_W'(cfg_height_raw) < lapedge_pkg::MIN_HEIGHT) begin
            cfg_height_clamped = lapedge_pkg::MIN_HEIGHT;
        end else if (lapedge_pkg::HEIGHT_W'(cfg_height_raw) > lapedge_pkg::LIM_HEIGHT) begin
            cfg_height_clamped = lapedge_pkg::LIM_HEIGHT;
        end else begin
            cfg_height_clamped = lapedge_pkg::HEIGHT_W'(cfg_height_raw);
        end
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= lapedge_pkg::RST_WIDTH;
            r_height    <= lapedge_pkg::RST_HEIGHT;
            r_threshold <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lapedge_pkg::REG_IMAGE_WIDTH:    r_width  <= cfg_width_clamped;
                lapedge_pkg::REG_IMAGE_HEIGHT:   r_height <= cfg_height_clamped;
                lapedge_pkg::REG_EDGE_THRESHOLD: begin
                    r_threshold <= signed'(i_cfg_data[lapedge_pkg::THR_W-1:0]);
                end
                default: ;
            endcase
        end
    end

    // input transfer; the pipeline moves whenever the skid stage is empty
    assign o_in_ready = !r_skid_valid;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign is_drain   = (i_action == lapedge_pkg::ACTION_DRAIN);
    assign step_go    = in_xfer && (!is_drain || r_drain_act);

    // a drain acts as a virtual pixel of the row below the frame
    assign step_row      = is_drain ? r_height : lapedge_pkg::HEIGHT_W'(r_in_row);
    assign step_col      = is_drain ? r_drain_col : lapedge_pkg::WIDTH_W'(r_in_col);
    assign step_col_zero = (step_col == '0);

    // decode the result position and its border cases from the step position
    always_comb begin
        step0.is_pixel  = !is_drain;
        step0.emit      = is_drain || (step_row >= lapedge_pkg::HEIGHT_W'(2))
                          || ((step_row == lapedge_pkg::HEIGHT_W'(1)) && !step_col_zero);
        step0.left_ref  = (step_col == lapedge_pkg::WIDTH_W'(1));
        step0.right_ref = step_col_zero || (step_col == r_width);
        step0.top_ref   = (!step_col_zero && (step_row == lapedge_pkg::HEIGHT_W'(1)))
                          || (step_col_zero && (step_row == lapedge_pkg::HEIGHT_W'(2)));
        step0.bot_ref   = !step_col_zero && (step_row == r_height);
        step0.frame_end = step0.bot_ref && (step_col == r_width);
        step0.addr      = step_col[lapedge_pkg::COL_W-1:0];
    end

    // raster counters and drain state
    assign in_col_next = lapedge_pkg::WIDTH_W'(r_in_col) + lapedge_pkg::WIDTH_W'(1);
    assign in_row_next = lapedge_pkg::HEIGHT_W'(r_in_row) + lapedge_pkg::HEIGHT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_drain_act <= 1'b0;
            r_drain_col <= '0;
        end else if (in_xfer) begin
            if (!is_drain) begin
                // a pixel abandons pending results unless it closes the frame
                r_drain_act <= 1'b0;
                if (in_col_next >= r_width) begin
                    r_in_col <= '0;
                    if (in_row_next >= r_height) begin
                        r_in_row    <= '0;
                        r_drain_act <= 1'b1;
                        r_drain_col <= '0;
                    end else begin
                        r_in_row <= in_row_next[lapedge_pkg::ROW_W-1:0];
                    end
                end else begin
                    r_in_col <= in_col_next[lapedge_pkg::COL_W-1:0];
                end
            end else if (r_drain_act) begin
                if (step0.frame_end) begin
                    r_drain_act <= 1'b0;
                end else begin
                    r_drain_col <= r_drain_col + lapedge_pkg::WIDTH_W'(1);
                end
            end
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= step_go;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_s1_step  <= step0;
            r_s1_pixel <= i_pixel_value;
        end
    end

    // line store read
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_rd_pair <= r_line_mem[step0.addr];
        end
    end

    // line store write: push the new pixel, keep the previous row
    always_ff @(posedge i_clk) begin
        if (o_in_ready && r_s1_valid && r_s1_step.is_pixel) begin
            r_line_mem[r_s1_step.addr] <= {r_rd_pair.newer, r_s1_pixel};
        end
    end

    // new window column; on a drain the bottom is always reflected away
    assign col_new = '{top: r_rd_pair.older, mid: r_rd_pair.newer, bot: r_s1_pixel};

    // column shift, every step moves one column in
    always_ff @(posedge i_clk) begin
        if (o_in_ready && r_s1_valid) begin
            r_col[0] <= r_col[1];
            r_col[1] <= r_col[2];
            r_col[2] <= col_new;
        end
    end

    // stage 2 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s2_valid <= r_s1_valid && r_s1_step.emit;
        end
    end

    // stage 2 payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_s2_step <= r_s1_step;
        end
    end

    // window with left and right border reflection, then top and bottom
    assign win_left  = lapedge_pkg::reflect_rows(r_s2_step.left_ref ? r_col[2] : r_col[0],
                                                 r_s2_step.top_ref, r_s2_step.bot_ref);
    assign win_mid   = lapedge_pkg::reflect_rows(r_col[1], r_s2_step.top_ref,
                                                 r_s2_step.bot_ref);
    assign win_right = lapedge_pkg::reflect_rows(r_s2_step.right_ref ? r_col[0] : r_col[2],
                                                 r_s2_step.top_ref, r_s2_step.bot_ref);

    // laplacian sum and threshold compare
    assign neigh_sum = lapedge_pkg::NSUM_W'(win_left.top) + lapedge_pkg::NSUM_W'(win_left.mid)
                     + lapedge_pkg::NSUM_W'(win_left.bot) + lapedge_pkg::NSUM_W'(win_mid.top)
                     + lapedge_pkg::NSUM_W'(win_mid.bot) + lapedge_pkg::NSUM_W'(win_right.top)
                     + lapedge_pkg::NSUM_W'(win_right.mid) + lapedge_pkg::NSUM_W'(win_right.bot);
    assign centre8   = {win_mid.mid, 3'b000};
    assign diff      = {1'b0, centre8} - {1'b0, neigh_sum};

    always_comb begin
        result.edge_sum  = signed'(diff);
        result.is_edge   = (result.edge_sum > r_threshold);
        result.row_end   = r_s2_step.right_ref;
        result.frame_end = r_s2_step.frame_end;
    end

    // output register and skid stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_out_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_s2_valid) begin
            if (r_out_valid && !i_out_ready) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register and skid stage payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_out_ready) begin
                r_out <= r_skid;
            end
        end else if (r_s2_valid) begin
            if (r_out_valid && !i_out_ready) begin
                r_skid <= result;
            end else begin
                r_out <= result;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_edge_sum  = r_out.edge_sum;
    assign o_is_edge   = r_out.is_edge;
    assign o_row_end   = r_out.row_end;
    assign o_frame_end = r_out.frame_end;

`ifndef NO_ASSERTIONS
    // the skid stage only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a result while the output register is empty");

    // pending results only exist with the input back at the frame start
    a_drain_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain_act |-> (r_in_col == '0 && r_in_row == '0))
        else $error("drain active away from the frame start");

    // a full skid stage freezes the pipeline
    a_frozen_on_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |=> $stable(r_s1_valid) && $stable(r_s2_valid) && $stable(r_col))
        else $error("pipeline moved while the skid stage was full");

    // the last result of a frame sits in the bottom right corner
    a_frame_end_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_step.frame_end) |-> (r_s2_step.right_ref && r_s2_step.bot_ref))
        else $error("frame end outside the bottom right corner");
`endif

endmodule

`default_nettype wire

>>> dv/lapedge_checker.sv
// checker of the laplacian edge filter: predicts every result and compares it
`timescale 1ns / 1ps

module lapedge_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    input  logic                                    i_cfg_ready,
    input  logic [lapedge_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lapedge_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                    i_in_valid,
    input  logic                                    i_in_ready,
    input  logic                                    i_action,
    input  logic [lapedge_pkg::PIX_W-1:0]           i_pixel_value,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_ready,
    input  logic signed [lapedge_pkg::SUM_W-1:0]    i_edge_sum,
    input  logic                                    i_is_edge,
    input  logic                                    i_row_end,
    input  logic                                    i_frame_end,
    output int                                      o_waiting,
    output int                                      o_fail_count,
    output int                                      o_checked
);

    localparam int RING_SIZE  = 2 * lapedge_pkg::MAX_WIDTH + 4;
    localparam int SHOW_LIMIT = 10;

    // model of the pixel history and raster positions
    lapedge_pkg::t_pixel                          pixel_ring [RING_SIZE];
    int                                           ring_slot;
    int                                           backlog;
    int                                           in_col;
    int                                           in_row;
    int                                           out_col;
    int                                           out_row;
    logic [lapedge_pkg::CFG_WIDTH_FIELD_W-1:0]    width_reg;
    logic [lapedge_pkg::CFG_HEIGHT_FIELD_W-1:0]   height_reg;
    logic signed [lapedge_pkg::THR_W-1:0]         threshold_reg;
    lapedge_pkg::t_result                         due_edges [$];
    int                                           fails;
    int                                           checked;

    function automatic int frame_width();
        int w;
        w = int'(width_reg);
        if (w < 2) w = 2;
        if (w > lapedge_pkg::MAX_WIDTH) w = lapedge_pkg::MAX_WIDTH;
        return w;
    endfunction

    function automatic int frame_height();
        int h;
        h = int'(height_reg);
        if (h < 2) h = 2;
        if (h > lapedge_pkg::MAX_HEIGHT) h = lapedge_pkg::MAX_HEIGHT;
        return h;
    endfunction

    // reflect-101 border: -1 reads 1, n reads n-2
    function automatic int mirror(input int v, input int n);
        if (v < 0) return 1;
        if (v >= n) return n - 2;
        return v;
    endfunction

    // pixel at an offset from the oldest pending position
    function automatic int ring_at(input int off);
        int pos;
        pos = (ring_slot - backlog + off) % RING_SIZE;
        if (pos < 0) pos += RING_SIZE;
        return int'(pixel_ring[pos]);
    endfunction

    // laplacian of the oldest pending position, then advance the output raster
    function automatic lapedge_pkg::t_result laplace_at_head();
        int                   w;
        int                   h;
        int                   rr;
        int                   cc;
        int                   dr;
        int                   dc;
        int                   acc;
        lapedge_pkg::t_result res;
        w   = frame_width();
        h   = frame_height();
        acc = 0;
        for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
                rr = mirror(out_row + dr, h);
                cc = mirror(out_col + dc, w);
                if (dr == 0 && dc == 0) begin
                    acc += 8 * ring_at((rr - out_row) * w + (cc - out_col));
                end else begin
                    acc -= ring_at((rr - out_row) * w + (cc - out_col));
                end
            end
        end
        res.edge_sum  = lapedge_pkg::SUM_W'(acc);
        res.is_edge   = (acc > int'(threshold_reg));
        res.row_end   = (out_col + 1 >= w);
        res.frame_end = res.row_end && (out_row + 1 >= h);
        if (backlog > 0) backlog--;
        if (res.frame_end) begin
            out_col = 0;
            out_row = 0;
            backlog = 0;
        end else if (res.row_end) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
        return res;
    endfunction

    // one accepted input transfer; returns 1 when it releases a result
    function automatic bit edge_step(input logic act, input lapedge_pkg::t_pixel pix,
                                     output lapedge_pkg::t_result res);
        bit at_start;
        int w;
        int h;
        at_start = (in_row == 0 && in_col == 0);
        w        = frame_width();
        h        = frame_height();
        res      = '0;
        if (act == lapedge_pkg::ACTION_DRAIN) begin
            if (at_start && backlog > 0) begin
                res = laplace_at_head();
                return 1'b1;
            end
            return 1'b0;
        end
        // a new frame abandons what the last one left pending
        if (at_start && backlog > 0) begin
            backlog = 0;
            out_col = 0;
            out_row = 0;
        end
        pixel_ring[ring_slot] = pix;
        ring_slot = (ring_slot + 1) % RING_SIZE;
        backlog++;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) in_row = 0;
        end
        if (backlog > w + 1) begin
            res = laplace_at_head();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // watch all three channels
    always @(posedge i_clk) begin
        lapedge_pkg::t_result want;
        lapedge_pkg::t_result got;
        bit                   produced;
        if (!i_rst_n) begin
            ring_slot     = 0;
            backlog       = 0;
            in_col        = 0;
            in_row        = 0;
            out_col       = 0;
            out_row       = 0;
            width_reg     = lapedge_pkg::CFG_WIDTH_FIELD_W'(640);
            height_reg    = lapedge_pkg::CFG_HEIGHT_FIELD_W'(480);
            threshold_reg = '0;
            fails         = 0;
            checked       = 0;
            due_edges.delete();
        end else begin
            // register write transfer
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lapedge_pkg::REG_IMAGE_WIDTH: begin
                        width_reg = i_cfg_data[lapedge_pkg::CFG_WIDTH_FIELD_W-1:0];
                    end
                    lapedge_pkg::REG_IMAGE_HEIGHT: begin
                        height_reg = i_cfg_data[lapedge_pkg::CFG_HEIGHT_FIELD_W-1:0];
                    end
                    lapedge_pkg::REG_EDGE_THRESHOLD: begin
                        threshold_reg = i_cfg_data[lapedge_pkg::THR_W-1:0];
                    end
                    default: ;
                endcase
            end
            // input transfer
            if (i_in_valid && i_in_ready) begin
                produced = edge_step(i_action, i_pixel_value, want);
                if (produced) due_edges = {due_edges, want};
            end
            // result transfer
            if (i_out_valid && i_out_ready) begin
                got.edge_sum  = i_edge_sum;
                got.is_edge   = i_is_edge;
                got.row_end   = i_row_end;
                got.frame_end = i_frame_end;
                checked++;
                if (due_edges.size() == 0) begin
                    fails++;
                    if (fails <= SHOW_LIMIT) begin
                        $display("%0t: result with none due: sum %0d edge %0b row %0b frame %0b",
                                 $time, $signed(got.edge_sum), got.is_edge, got.row_end,
                                 got.frame_end);
                    end
                end else begin
                    want = due_edges.pop_front();
                    if (want.edge_sum !== got.edge_sum || want.is_edge !== got.is_edge ||
                        want.row_end !== got.row_end || want.frame_end !== got.frame_end) begin
                        fails++;
                        if (fails <= SHOW_LIMIT) begin
                            $display("%0t: result differs: due sum %0d edge %0b row %0b frame %0b",
                                     $time, $signed(want.edge_sum), want.is_edge,
                                     want.row_end, want.frame_end);
                            $display("%0t:                 got sum %0d edge %0b row %0b frame %0b",
                                     $time, $signed(got.edge_sum), got.is_edge,
                                     got.row_end, got.frame_end);
                        end
                    end
                end
            end
        end
        o_waiting    <= due_edges.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

>>> dv/tb.sv
// top of the laplacian edge filter testbench: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module tb;

    localparam logic [lapedge_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int IDLE_PCT     = 37;
    localparam int RANDOM_ITEMS = 1250;
    localparam int FLAT_LEVEL   = 77;
    localparam int SETTLE_CYCLES = 8;

    typedef enum int {TEX_NOISE, TEX_BINARY, TEX_RAMP, TEX_FLAT} t_texture;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [lapedge_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [lapedge_pkg::CFG_DATA_W-1:0]   cfg_data;
    logic                                 in_valid;
    logic                                 in_ready;
    logic                                 action;
    lapedge_pkg::t_pixel                  pixel_value;
    logic                                 out_valid;
    logic                                 out_ready;
    logic signed [lapedge_pkg::SUM_W-1:0] edge_sum;
    logic                                 is_edge;
    logic                                 row_end;
    logic                                 frame_end;
    logic                                 calm;
    int                                   waiting;
    int                                   fail_count;
    int                                   checked;
    int                                   frames;
    int                                   pixels_sent;
    int                                   drains_sent;
    int                                   random_items;
    int                                   cur_width;
    int                                   cur_height;

    laplacian_edge_threshold_3x3 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_action      (action),
        .i_pixel_value (pixel_value),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_edge_sum    (edge_sum),
        .o_is_edge     (is_edge),
        .o_row_end     (row_end),
        .o_frame_end   (frame_end)
    );

    lapedge_checker edge_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_action      (action),
        .i_pixel_value (pixel_value),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_edge_sum    (edge_sum),
        .i_is_edge     (is_edge),
        .i_row_end     (row_end),
        .i_frame_end   (frame_end),
        .o_waiting     (waiting),
        .o_fail_count  (fail_count),
        .o_checked     (checked)
    );

    // 125 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // hard stop
    initial begin
        #400_000;
        $display("timed out with %0d results still due", waiting);
        $display("Mismatches found");
        $finish;
    end

    function automatic int clamp_size(input int raw, input int hi);
        if (raw < 2) return 2;
        if (raw > hi) return hi;
        return raw;
    endfunction

    function automatic lapedge_pkg::t_pixel texel(input t_texture tex, input int r, input int c);
        case (tex)
            TEX_NOISE:  return lapedge_pkg::t_pixel'($urandom);
            TEX_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            TEX_RAMP:   return lapedge_pkg::t_pixel'(r * 9 + c * 5 + $urandom_range(0, 3));
            default:    return lapedge_pkg::t_pixel'(FLAT_LEVEL);
        endcase
    endfunction

    // mostly near the typical sum range, sometimes anywhere, sometimes the ends
    function automatic int pick_threshold();
        case ($urandom_range(0, 9))
            0:       return -2048;
            1:       return 2047;
            2, 3:    return int'($urandom_range(0, 4095)) - 2048;
            default: return int'($urandom_range(0, 800)) - 400;
        endcase
    endfunction

    // one input transfer, with a random gap in front
    task automatic transfer(input logic act, input lapedge_pkg::t_pixel pix);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        in_valid    <= 1'b1;
        action      <= act;
        pixel_value <= pix;
        do @(posedge i_clk); while (!in_ready);
        if (act == lapedge_pkg::ACTION_PIXEL) pixels_sent++;
        else drains_sent++;
    endtask

    // one register write transfer; the caller lowers valid after the last one
    task automatic write_reg(input logic [lapedge_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lapedge_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    // hold the input until every due result is out and the pipeline is empty
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all three registers in a rotated order, unused bits random
    task automatic configure(input int w_raw, input int h_raw, input int thr, input bit spare);
        int first;
        int k;
        first = $urandom_range(0, 2);
        if (spare) write_reg(REG_SPARE, lapedge_pkg::CFG_DATA_W'($urandom));
        for (k = 0; k < 3; k++) begin
            case ((first + k) % 3)
                0: write_reg(lapedge_pkg::REG_IMAGE_WIDTH,
                             {1'($urandom_range(0, 1)),
                              lapedge_pkg::CFG_WIDTH_FIELD_W'(w_raw)});
                1: write_reg(lapedge_pkg::REG_IMAGE_HEIGHT, lapedge_pkg::CFG_DATA_W'(h_raw));
                default: write_reg(lapedge_pkg::REG_EDGE_THRESHOLD,
                                   {1'($urandom_range(0, 1)), lapedge_pkg::THR_W'(thr)});
            endcase
        end
        cfg_valid  <= 1'b0;
        cur_width  = clamp_size(w_raw & 'hFFF, lapedge_pkg::MAX_WIDTH);
        cur_height = clamp_size(h_raw & 'h1FFF, lapedge_pkg::MAX_HEIGHT);
    endtask

    // one frame of pixels, optional stray drains inside, then the drains
    task automatic run_frame(input t_texture tex, input int drains, input bit noise);
        int r;
        int c;
        for (r = 0; r < cur_height; r++) begin
            for (c = 0; c < cur_width; c++) begin
                if (noise && $urandom_range(0, 99) < 3) begin
                    transfer(lapedge_pkg::ACTION_DRAIN, lapedge_pkg::t_pixel'($urandom));
                end
                transfer(lapedge_pkg::ACTION_PIXEL, texel(tex, r, c));
            end
        end
        repeat (drains) transfer(lapedge_pkg::ACTION_DRAIN, lapedge_pkg::t_pixel'($urandom));
        frames++;
    endtask

    // stimulus
    initial begin
        lapedge_pkg::t_pixel dark_spot [6];
        lapedge_pkg::t_pixel bright_spot [6];
        t_texture            tex;
        int                  phase;
        int                  w_raw;
        int                  h_raw;
        int                  nframes;
        int                  f;
        int                  k;
        int                  drains;
        i_rst_n      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        action       = lapedge_pkg::ACTION_PIXEL;
        pixel_value  = '0;
        calm         = 1'b0;
        frames       = 0;
        pixels_sent  = 0;
        drains_sent  = 0;
        random_items = 0;
        dark_spot    = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        bright_spot  = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // dark centre in a bright 3x2 frame under the reset threshold
        write_reg(lapedge_pkg::REG_IMAGE_WIDTH, lapedge_pkg::CFG_DATA_W'(3));
        write_reg(lapedge_pkg::REG_IMAGE_HEIGHT, lapedge_pkg::CFG_DATA_W'(2));
        cfg_valid  <= 1'b0;
        cur_width  = 3;
        cur_height = 2;
        transfer(lapedge_pkg::ACTION_DRAIN, 8'hFF);
        for (k = 0; k < 6; k++) begin
            if (k == 3) transfer(lapedge_pkg::ACTION_DRAIN, 8'h00);
            transfer(lapedge_pkg::ACTION_PIXEL, dark_spot[k]);
        end
        repeat (4) transfer(lapedge_pkg::ACTION_DRAIN, 8'h00);
        frames++;

        // bright centre in a dark frame, lowest threshold
        settle();
        configure(3, 2, -2048, 1'b0);
        for (k = 0; k < 6; k++) transfer(lapedge_pkg::ACTION_PIXEL, bright_spot[k]);
        repeat (4) transfer(lapedge_pkg::ACTION_DRAIN, 8'hFF);
        frames++;

        // random phases, two of them with a wide and a tall frame
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            settle();
            calm <= (phase >= 8 && phase < 14);
            if (phase == 5) begin
                configure(64, 1, pick_threshold(), 1'b1);
                run_frame(TEX_NOISE, cur_width + 1, 1'b0);
                random_items += cur_width * cur_height + cur_width + 1;
            end else if (phase == 11) begin
                configure(1, 40, pick_threshold(), 1'b0);
                run_frame(TEX_BINARY, cur_width + 1, 1'b0);
                random_items += cur_width * cur_height + cur_width + 1;
            end else begin
                case ($urandom_range(0, 9))
                    0:       w_raw = $urandom_range(0, 1);
                    1:       w_raw = $urandom_range(11, 40);
                    default: w_raw = $urandom_range(2, 10);
                endcase
                case ($urandom_range(0, 9))
                    0:       h_raw = $urandom_range(0, 1);
                    1:       h_raw = $urandom_range(7, 12);
                    default: h_raw = $urandom_range(2, 6);
                endcase
                configure(w_raw, h_raw, pick_threshold(), $urandom_range(0, 9) == 0);
                nframes = $urandom_range(1, 3);
                for (f = 0; f < nframes; f++) begin
                    tex    = t_texture'($urandom_range(0, 3));
                    drains = cur_width + 1;
                    // leave some results behind for the next frame to abandon
                    if (f < nframes - 1 && $urandom_range(0, 6) == 0) begin
                        drains = $urandom_range(0, cur_width);
                    end else if ($urandom_range(0, 4) == 0) begin
                        drains += $urandom_range(1, 2);
                    end
                    run_frame(tex, drains, 1'b1);
                    random_items += cur_width * cur_height + drains;
                end
            end
            phase++;
        end

        settle();
        $display("covered %0d frames, %0d pixel and %0d drain transfers, %0d results checked",
                 frames, pixels_sent, drains_sent, checked);
        $display("frame sizes from 2x2 up to 64 wide and 40 high, thresholds -2048 to 2047");
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> laplacian_edge_threshold_3x3.f
hdl/lapedge_pkg.sv
hdl/laplacian_edge_threshold_3x3.sv
dv/lapedge_checker.sv
dv/tb.sv
